// ===== hdl/lsbt_pkg.sv =====
package lsbt_pkg;

  localparam int DATA_W       = 32;
  localparam int TERM_W       = 16;
  localparam int PHASE_W      = 16;
  localparam int IN_TDATA_W   = 144;
  localparam int OUT_TDATA_W  = 64;
  localparam int CORDIC_STEPS = 24;
  localparam int MUL_W        = 33;

  localparam logic [31:0] HALF_ROOT_Q32  = 32'd3037000500;
  localparam logic [31:0] INV_GAIN_Q32   = 32'd2608131496;
  localparam logic [47:0] SIN_FLOOR_CODE = 48'd107374;
  // 2^31 / 1e8, floored
  localparam logic [63:0] CROSS_LIMIT    = 64'd21;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/lsbt_mul.sv =====
module lsbt_mul (
  input  logic                                 clk,
  input  logic signed [lsbt_pkg::MUL_W-1:0]    a,
  input  logic signed [lsbt_pkg::MUL_W-1:0]    b,
  output logic signed [2*lsbt_pkg::MUL_W-1:0]  p
);
  import lsbt_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hdl/lsbt_sqdiv.sv =====
module lsbt_sqdiv (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        acc,
  input  logic [47:0]        sq,
  output logic               done,
  output logic signed [31:0] q_out
);
  import lsbt_pkg::*;

  typedef enum logic [2:0] {SD_IDLE, SD_SQRT, SD_PREP, SD_DIV, SD_FIN} sd_state_t;
  sd_state_t state;

  logic [63:0] v;
  logic [63:0] r;
  logic [4:0]  k;
  logic        neg;
  logic [63:0] mag;
  logic [70:0] num;
  logic [31:0] rem;
  logic [33:0] q;
  logic        ovf;
  logic [6:0]  cnt;

  logic [63:0] bitv;
  logic [63:0] trial;
  logic        sq_ge;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        dv_ge;
  logic [31:0] d;
  logic        big_pos;
  logic        big_neg;

  assign d       = r[31:0];
  assign bitv    = 64'd1 << {k, 1'b0};
  assign trial   = r + bitv;
  assign sq_ge   = v >= trial;
  assign rem_sh  = {rem, num[70]};
  assign rem_sub = rem_sh - {1'b0, d};
  assign dv_ge   = rem_sh >= {1'b0, d};
  assign big_pos = ovf | (q[33:31] != 3'd0);
  assign big_neg = ovf | (q[33:32] != 2'd0) | (q[31] & (q[30:0] != 31'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == SD_FIN) || ((state == SD_PREP) && (d == 32'd0));
      case (state)
        SD_IDLE: begin
          if (start) begin
            v     <= {1'b0, sq, 15'd0};
            r     <= 64'd0;
            k     <= 5'd31;
            neg   <= acc[63];
            mag   <= acc[63] ? (~acc + 64'd1) : acc;
            state <= SD_SQRT;
          end
        end
        SD_SQRT: begin
          if (sq_ge) begin
            v <= v - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          if (k == 5'd0) state <= SD_PREP;
          k <= k - 5'd1;
        end
        SD_PREP: begin
          if (d == 32'd0) begin
            q_out <= '0;
            state <= SD_IDLE;
          end else begin
            num   <= {mag, 7'd0} + {39'd0, (d >> 1)};
            rem   <= 32'd0;
            q     <= 34'd0;
            ovf   <= 1'b0;
            cnt   <= 7'd70;
            state <= SD_DIV;
          end
        end
        SD_DIV: begin
          rem <= dv_ge ? rem_sub[31:0] : rem_sh[31:0];
          num <= {num[69:0], 1'b0};
          q   <= {q[32:0], dv_ge};
          ovf <= ovf | q[33];
          if (cnt == 7'd0) state <= SD_FIN;
          cnt <= cnt - 7'd1;
        end
        SD_FIN: begin
          if (neg) q_out <= big_neg ? 32'sh80000000 : -$signed(q[31:0]);
          else     q_out <= big_pos ? 32'sh7FFFFFFF : $signed(q[31:0]);
          state <= SD_IDLE;
        end
        default: state <= SD_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lsbt_cordic.sv =====
module lsbt_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [51:0]  x0,
  input  logic signed [51:0]  y0,
  input  logic [15:0]         phase,
  output logic                done,
  output logic signed [31:0]  x_out,
  output logic signed [31:0]  y_out
);
  import lsbt_pkg::*;

  typedef enum logic [1:0] {CR_IDLE, CR_RUN, CR_FIN} cr_state_t;
  cr_state_t state;

  logic signed [51:0] x;
  logic signed [51:0] y;
  logic signed [33:0] z;
  logic [4:0]         i;

  logic signed [33:0] z_in;
  logic signed [51:0] dx;
  logic signed [51:0] dy;
  logic signed [33:0] at;
  logic signed [51:0] xr;
  logic signed [51:0] yr;
  logic signed [35:0] xs;
  logic signed [35:0] ys;

  assign z_in = 34'(signed'({phase, 16'd0}));
  assign dx   = y >>> i;
  assign dy   = x >>> i;
  assign at   = $signed({2'b00, atan_turn(i)});
  assign xr   = x + 52'sd32768;
  assign yr   = y + 52'sd32768;
  assign xs   = 36'(xr >>> 16);
  assign ys   = 36'(yr >>> 16);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] val);
    logic signed [31:0] o;
    if (val > 36'sd2147483647)       o = 32'sh7FFFFFFF;
    else if (val < -36'sd2147483648) o = 32'sh80000000;
    else                             o = val[31:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CR_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == CR_FIN);
      case (state)
        CR_IDLE: begin
          if (start) begin
            i <= 5'd0;
            // fold angles beyond a quarter turn with a half-turn flip
            if (z_in > 34'sd1073741824) begin
              x <= -x0; y <= -y0; z <= z_in - 34'sd2147483648;
            end else if (z_in < -34'sd1073741824) begin
              x <= -x0; y <= -y0; z <= z_in + 34'sd2147483648;
            end else begin
              x <= x0; y <= y0; z <= z_in;
            end
            state <= CR_RUN;
          end
        end
        CR_RUN: begin
          if (!z[33]) begin
            x <= x - dx; y <= y + dy; z <= z - at;
          end else begin
            x <= x + dx; y <= y - dy; z <= z + at;
          end
          if (i == 5'(CORDIC_STEPS - 1)) state <= CR_FIN;
          i <= i + 5'd1;
        end
        CR_FIN: begin
          x_out <= sat32(xs);
          y_out <= sat32(ys);
          state <= CR_IDLE;
        end
        default: state <= CR_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lomb_scargle_bin_transform_top.sv =====
// lomb-scargle transform, one frequency bin at a time
// input stream: tuser = cmd (1 starts a segment), tlast = last sample of a
// frequency, tdata carries sample, time, cos/sin terms, phase and scaled sum
// a start transfer yields the zero-frequency bin (tuser = 1)
// a sample transfer passes through one shared 33x33 multiplier,
// which forms c*c, s*s, c*s, x*c, x*s and t*c*s in turn
// on the last sample the bin runs the shift-subtract unit (a square root,
// then a divide) for the real part and, unless the sine energy is tiny,
// for the imaginary part, then two gain multiplies and 24 cordic steps
// tready is high only while the sequencer is idle; one item at a time
// the result sits in an output register, so the next item is taken while a
// bin waits; if the receiver stalls with a bin still held, the next bin
// waits in the sequencer and the input stays blocked
// reset clears the sums, the fallback imaginary value and the output valid
module lomb_scargle_bin_transform_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_value, sample_time, cos_term, sin_term, bin_phase, scaled_sum
  input  logic [lsbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bin_real, bin_imag
  output logic [lsbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // zero_bin
  output logic         m_axis_tuser
);
  import lsbt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FB_MUL, ST_FB_WR, ST_CC, ST_SS, ST_CS, ST_XC, ST_XS, ST_TCS,
    ST_ACC, ST_RE_GO, ST_RE_WAIT, ST_IM_GO, ST_IM_WAIT, ST_KX, ST_KY, ST_KW,
    ST_ROT_WAIT, ST_EMIT
  } state_t;
  state_t state;

  logic signed [31:0] xv, tv, ssum;
  logic signed [15:0] cv, sv;
  logic [15:0]        phase;
  logic               last;

  logic [63:0] cross_acc, real_acc, imag_acc;
  logic [47:0] cos_sq_acc, sin_sq_acc;
  logic [31:0] fallback_imag;
  logic signed [31:0] cs_prod;
  logic signed [31:0] re, im;
  logic signed [51:0] rx;
  logic signed [31:0] res_re, res_im;
  logic               res_zero;

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] mp;
  logic signed [65:0]        mp_rnd;
  logic signed [51:0]        scaled;
  logic [31:0]               ss_mag;
  logic [31:0]               fb_mag;
  logic [63:0]               fb_sum;
  logic [63:0]               cross_mag;

  logic               sd_start;
  logic               sd_done;
  logic signed [31:0] sd_q;
  logic               cr_start;
  logic               cr_done;
  logic signed [31:0] cr_x, cr_y;

  assign s_axis_tready = (state == ST_IDLE);

  assign ss_mag    = ssum[31] ? (~ssum + 32'd1) : ssum;
  assign fb_sum    = mp[63:0] + 64'h0000_0000_8000_0000;
  assign fb_mag    = fb_sum[63:32];
  assign mp_rnd    = mp + 66'sd32768;
  assign scaled    = 52'(mp_rnd >>> 16);
  assign cross_mag = cross_acc[63] ? (~cross_acc + 64'd1) : cross_acc;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_FB_MUL: begin ma = $signed({1'b0, ss_mag}); mb = $signed({1'b0, HALF_ROOT_Q32}); end
      ST_CC:     begin ma = 33'(cv); mb = 33'(cv); end
      ST_SS:     begin ma = 33'(sv); mb = 33'(sv); end
      ST_CS:     begin ma = 33'(cv); mb = 33'(sv); end
      ST_XC:     begin ma = 33'(xv); mb = 33'(cv); end
      ST_XS:     begin ma = 33'(xv); mb = 33'(sv); end
      ST_TCS:    begin ma = 33'(tv); mb = 33'(cs_prod); end
      ST_KX:     begin ma = 33'(re); mb = $signed({1'b0, INV_GAIN_Q32}); end
      ST_KY:     begin ma = 33'(im); mb = $signed({1'b0, INV_GAIN_Q32}); end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  assign sd_start = (state == ST_RE_GO) || (state == ST_IM_GO);

  lsbt_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (mp)
  );

  lsbt_sqdiv u_sqdiv (
    .clk   (clk),
    .rst   (rst),
    .start (sd_start),
    .acc   ((state == ST_IM_GO) ? imag_acc : real_acc),
    .sq    ((state == ST_IM_GO) ? sin_sq_acc : cos_sq_acc),
    .done  (sd_done),
    .q_out (sd_q)
  );

  lsbt_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cr_start),
    .x0    (rx),
    .y0    (scaled),
    .phase (phase),
    .done  (cr_done),
    .x_out (cr_x),
    .y_out (cr_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cross_acc     <= '0;
      real_acc      <= '0;
      imag_acc      <= '0;
      cos_sq_acc    <= '0;
      sin_sq_acc    <= '0;
      fallback_imag <= '0;
      m_axis_tvalid <= 1'b0;
      cr_start      <= 1'b0;
    end else begin
      // rotation starts while the scaled imaginary part is on the multiplier output
      cr_start <= (state == ST_KY);
      if (m_axis_tvalid && m_axis_tready && (state != ST_EMIT)) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            xv    <= s_axis_tdata[31:0];
            tv    <= s_axis_tdata[63:32];
            cv    <= s_axis_tdata[79:64];
            sv    <= s_axis_tdata[95:80];
            phase <= s_axis_tdata[111:96];
            ssum  <= s_axis_tdata[143:112];
            last  <= s_axis_tlast;
            state <= s_axis_tuser ? ST_FB_MUL : ST_CC;
          end
        end
        ST_FB_MUL: state <= ST_FB_WR;
        ST_FB_WR: begin
          fallback_imag <= ssum[31] ? (~fb_mag + 32'd1) : fb_mag;
          cross_acc  <= '0;
          real_acc   <= '0;
          imag_acc   <= '0;
          cos_sq_acc <= '0;
          sin_sq_acc <= '0;
          res_re     <= ssum;
          res_im     <= '0;
          res_zero   <= 1'b1;
          state      <= ST_EMIT;
        end
        ST_CC: state <= ST_SS;
        ST_SS: begin
          cos_sq_acc <= cos_sq_acc + mp[47:0];
          state      <= ST_CS;
        end
        ST_CS: begin
          sin_sq_acc <= sin_sq_acc + mp[47:0];
          state      <= ST_XC;
        end
        ST_XC: begin
          cs_prod <= mp[31:0];
          state   <= ST_XS;
        end
        ST_XS: begin
          real_acc <= real_acc + mp[63:0];
          state    <= ST_TCS;
        end
        ST_TCS: begin
          imag_acc <= imag_acc + mp[63:0];
          state    <= ST_ACC;
        end
        ST_ACC: begin
          cross_acc <= cross_acc + 64'(mp >>> 15);
          state     <= last ? ST_RE_GO : ST_IDLE;
        end
        ST_RE_GO: state <= ST_RE_WAIT;
        ST_RE_WAIT: begin
          if (sd_done) begin
            re <= sd_q;
            // tiny sine energy: imaginary part falls back
            if (sin_sq_acc <= SIN_FLOOR_CODE) begin
              im    <= (cross_mag > CROSS_LIMIT) ? 32'sd0 : $signed(fallback_imag);
              state <= ST_KX;
            end else begin
              state <= ST_IM_GO;
            end
          end
        end
        ST_IM_GO: state <= ST_IM_WAIT;
        ST_IM_WAIT: begin
          if (sd_done) begin
            im    <= sd_q;
            state <= ST_KX;
          end
        end
        ST_KX: state <= ST_KY;
        ST_KY: begin
          rx    <= scaled;
          state <= ST_KW;
        end
        ST_KW: state <= ST_ROT_WAIT;
        ST_ROT_WAIT: begin
          if (cr_done) begin
            res_re     <= cr_x;
            res_im     <= cr_y;
            res_zero   <= 1'b0;
            cross_acc  <= '0;
            real_acc   <= '0;
            imag_acc   <= '0;
            cos_sq_acc <= '0;
            sin_sq_acc <= '0;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_im, res_re};
            m_axis_tuser  <= res_zero;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/lomb_scargle_bin_transform_top_tb.sv =====
`timescale 1ns / 100ps

module lomb_scargle_bin_transform_top_tb;
  import lsbt_pkg::*;

  typedef struct packed {
    logic        zero_flag;
    logic [31:0] imag_part;
    logic [31:0] real_part;
  } bin_t;

  typedef struct {
    bit          start;
    logic [31:0] xval;
    logic [31:0] tval;
    logic [15:0] cval;
    logic [15:0] sval;
    logic [15:0] phase;
    bit          last;
    logic [31:0] ssum;
    bit          has_exp;
    bin_t        exp_bin;
  } row_t;

  localparam int NUM_RANDOM = 1400;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  lomb_scargle_bin_transform_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // predictor state
  longint   cross_sum, real_sum, imag_sum;
  bit [47:0] cos_energy, sin_energy;
  longint   fallback_im;

  bin_t bin_queue[$];
  int   error_count;
  bit   calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint fshift(input longint v, input int k);
    return v >>> k;
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint normalize(input longint acc, input bit [47:0] energy);
    longint unsigned mag, d, qh, rm, q;
    bit neg;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    d = int_sqrt({16'd0, energy} << 15);
    if (d == 0) return 0;
    qh = mag / d;
    rm = mag % d;
    if (qh >= (64'd1 << 25)) q = 64'd1 << 32;
    else q = qh * 128 + (rm * 128 + d / 2) / d;
    if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic void rotate_bin(input longint re, input longint im,
                                     input logic [15:0] phase,
                                     output longint ore, output longint oim);
    longint x, y, z, dx, dy, gain;
    gain = longint'({32'd0, INV_GAIN_Q32});
    x = fshift(re * gain + 32768, 16);
    y = fshift(im * gain + 32768, 16);
    z = longint'({phase, 16'd0});
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      x = -x; y = -y; z -= 64'sd2147483648;
    end else if (z < -64'sd1073741824) begin
      x = -x; y = -y; z += 64'sd2147483648;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({32'd0, atan_turn(i[4:0])});
      end else begin
        x += dx; y -= dy; z += longint'({32'd0, atan_turn(i[4:0])});
      end
    end
    ore = sat_q(fshift(x + 32768, 16));
    oim = sat_q(fshift(y + 32768, 16));
  endfunction

  function automatic void clear_sums();
    cross_sum = 0; real_sum = 0; imag_sum = 0;
    cos_energy = '0; sin_energy = '0;
  endfunction

  // returns 1 when the item yields a bin
  function automatic bit predict_bin(input row_t r, output bin_t b);
    longint ss, x, t, c, s, re, im, rr, ri, cm;
    longint unsigned mag, f;
    if (r.start) begin
      ss = longint'(signed'(r.ssum));
      mag = (ss < 0) ? -ss : ss;
      f = (mag * {32'd0, HALF_ROOT_Q32} + 64'd2147483648) >> 32;
      fallback_im = (ss < 0) ? -longint'(f) : longint'(f);
      fallback_im = longint'(signed'(fallback_im[31:0]));
      clear_sums();
      b.real_part = r.ssum;
      b.imag_part = '0;
      b.zero_flag = 1'b1;
      return 1;
    end
    x = longint'(signed'(r.xval));
    t = longint'(signed'(r.tval));
    c = longint'(signed'(r.cval));
    s = longint'(signed'(r.sval));
    cross_sum += fshift(t * (c * s), 15);
    cos_energy += 48'(c * c);
    sin_energy += 48'(s * s);
    real_sum += x * c;
    imag_sum += x * s;
    if (!r.last) return 0;
    re = normalize(real_sum, cos_energy);
    if (sin_energy <= SIN_FLOOR_CODE) begin
      cm = (cross_sum < 0) ? -cross_sum : cross_sum;
      // the most negative value negated stays negative; treat as huge
      im = (cm < 0 || longint'(cm) > longint'(CROSS_LIMIT)) ? 0 : fallback_im;
    end else begin
      im = normalize(imag_sum, sin_energy);
    end
    rotate_bin(re, im, r.phase, rr, ri);
    clear_sums();
    b.real_part = rr[31:0];
    b.imag_part = ri[31:0];
    b.zero_flag = 1'b0;
    return 1;
  endfunction

  function automatic row_t mk(input bit st, input logic [31:0] x, input logic [31:0] t,
                              input logic [15:0] c, input logic [15:0] s,
                              input logic [15:0] ph, input bit lst,
                              input logic [31:0] sum);
    row_t r;
    r.start = st; r.xval = x; r.tval = t; r.cval = c; r.sval = s;
    r.phase = ph; r.last = lst; r.ssum = sum; r.has_exp = 0; r.exp_bin = '0;
    return r;
  endfunction

  function automatic row_t mk_zero(input logic [31:0] sum);
    row_t r;
    r = mk(1, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
           1'($urandom), sum);
    r.has_exp = 1;
    r.exp_bin = {1'b1, 32'd0, sum};
    return r;
  endfunction

  function automatic row_t rand_sample(input bit lst);
    row_t r;
    int k;
    r = mk(0, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), lst,
           $urandom);
    k = $urandom_range(0, 9);
    if (k < 3) begin
      r.xval = $urandom_range(0, 1 << 20) - (1 << 19);
      r.tval = $urandom_range(0, 1 << 22);
    end
    if (k == 4) r.sval = 16'($urandom_range(0, 6) - 3);   // tiny sine energy
    if (k == 5) begin
      r.sval = 0;
      r.tval = $urandom_range(0, 3);
    end
    if (k == 6) r.cval = 0;
    return r;
  endfunction

  task automatic send_item(input row_t r);
    bin_t b;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.start;
    s_axis_tlast  <= r.last;
    s_axis_tdata  <= {r.ssum, r.phase, r.sval, r.cval, r.tval, r.xval};
    do @(posedge clk); while (!s_axis_tready);
    if (predict_bin(r, b)) begin
      if (r.has_exp && b !== r.exp_bin) begin
        report_mismatch("table row", b.real_part, r.exp_bin.real_part);
      end
      bin_queue.push_back(b);
    end
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // receiver side
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    bin_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (bin_queue.size() == 0) begin
        report_mismatch("unexpected bin", m_axis_tdata[31:0], '0);
      end else begin
        want = bin_queue.pop_front();
        if (m_axis_tdata[31:0] !== want.real_part)
          report_mismatch("bin_real", m_axis_tdata[31:0], want.real_part);
        if (m_axis_tdata[63:32] !== want.imag_part)
          report_mismatch("bin_imag", m_axis_tdata[63:32], want.imag_part);
        if (m_axis_tuser !== want.zero_flag)
          report_mismatch("zero_bin", m_axis_tuser, want.zero_flag);
      end
    end
  end

  initial begin
    row_t table_rows[$];
    int   n, waited;
    error_count = 0;
    calm = 0;
    clear_sums();
    fallback_im = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    table_rows.push_back(mk(0, 32'h0001_0000, 32'h0001_0000, 16'h7FFF, 16'h0000,
                            16'h0000, 1, 0));          // fallback after reset
    table_rows.push_back(mk_zero(32'h7FFF_FFFF));
    table_rows.push_back(mk_zero(32'h8000_0000));
    table_rows.push_back(mk_zero(32'h0000_0000));
    table_rows.push_back(mk_zero(32'hFFFF_0000));
    table_rows.push_back(mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF,
                            16'h4000, 0, 0));
    table_rows.push_back(mk(0, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
                            16'hC000, 1, 0));
    table_rows.push_back(mk(0, 32'h0002_0000, 32'h0, 16'h0000, 16'h4000,
                            16'hFFFF, 1, 0));          // zero cosine energy
    table_rows.push_back(mk(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF,
                            16'h8000, 1, 0));
    table_rows.push_back(mk_zero(32'h0123_4567));
    table_rows.push_back(mk(0, 32'h0001_0000, 32'h0000_0001, 16'h4000, 16'h0001,
                            16'h2000, 1, 0));          // tiny sine, small cross
    table_rows.push_back(mk(0, 32'h0001_0000, 32'h0100_0000, 16'h4000, 16'h0003,
                            16'h6000, 1, 0));          // tiny sine, large cross
    table_rows.push_back(mk(0, 32'h0005_0000, 32'h0001_0000, 16'h2000, 16'h3000,
                            16'h1234, 0, 0));          // start mid frequency
    table_rows.push_back(mk_zero(32'hFEDC_BA98));
    table_rows.push_back(mk(0, 32'h0000_8000, 32'h0000_0000, 16'h5A82, 16'hA57E,
                            16'hA000, 1, 0));
    table_rows.push_back(mk(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            16'h0001, 1, 0));
    foreach (table_rows[i]) send_item(table_rows[i]);
    s_axis_tvalid <= 1'b0;

    // hold off until every bin is back
    while (bin_queue.size() != 0) @(negedge clk);

    n = 0;
    while (n < NUM_RANDOM) begin
      calm = (n >= 500 && n < 700);
      if ($urandom_range(0, 19) == 0) begin
        send_item(mk_zero($urandom));
        n++;
      end else begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          send_item(rand_sample(j == len - 1));
          n++;
        end
      end
    end
    calm = 0;
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (bin_queue.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (400) @(negedge clk);
    if (error_count == 0 && bin_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lsbt_pkg.sv
hdl/lsbt_mul.sv
hdl/lsbt_sqdiv.sv
hdl/lsbt_cordic.sv
hdl/lomb_scargle_bin_transform_top.sv
dv/lomb_scargle_bin_transform_top_tb.sv
